### sv/fuat_pkg.sv
// Shared types, codes and constants for the FU-A reassembly tracker.
package fuat_pkg;

   localparam logic [7:0] FU_S_BIT       = 8'b1000_0000;
   localparam logic [7:0] FU_E_BIT       = 8'b0100_0000;
   localparam logic [7:0] FU_R_BIT       = 8'b0010_0000;
   localparam logic [7:0] TYPE_BITS      = 8'b0001_1111;
   localparam logic [7:0] PREFIX_BITS    = 8'b1110_0000;
   localparam logic [7:0] NRI_BITS       = 8'b0110_0000;
   localparam logic [7:0] FU_A_TYPE      = 8'd28;
   localparam logic [7:0] MAX_SINGLE     = 8'd23;
   localparam logic [23:0] MAX_NAL_RESET = 24'd1048576;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 160;

   typedef enum logic [4:0] {
      ST_ACCEPT        = 5'd0,
      ST_DONE          = 5'd1,
      ERR_EMPTY        = 5'd2,
      ERR_FORBIDDEN    = 5'd3,
      ERR_IND_TYPE     = 5'd4,
      ERR_TRUNC        = 5'd5,
      ERR_RESERVED     = 5'd6,
      ERR_START_END    = 5'd7,
      ERR_ORIG_TYPE    = 5'd8,
      ERR_MARKER       = 5'd9,
      ERR_START_ACTIVE = 5'd10,
      ERR_START_SIZE   = 5'd11,
      ERR_NO_UNIT      = 5'd12,
      ERR_SEQ          = 5'd13,
      ERR_SSRC         = 5'd14,
      ERR_TIMESTAMP    = 5'd15,
      ERR_PAY_TYPE     = 5'd16,
      ERR_HEADER       = 5'd17,
      ERR_TOO_LONG     = 5'd18
   } status_type;

   typedef struct packed {
      logic [7:0]  indicator_byte;
      logic [7:0]  fu_header_byte;
      logic [15:0] payload_len;
      logic [15:0] seq_num;
      logic [31:0] rtp_timestamp;
      logic [31:0] stream_ssrc;
      logic [6:0]  pay_type;
      logic        marker_in;
   } desc_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  err_offset;
      logic [23:0] write_offset;
      logic [7:0]  unit_header;
      logic [23:0] nal_length;
      logic [15:0] first_seq;
      logic [15:0] last_seq;
      logic [31:0] unit_timestamp;
      logic [31:0] unit_ssrc;
      logic        marker_out;
      logic        unit_active;
   } result_type;

endpackage

### sv/fuat_core.sv
// Packet checks, unit state and results: one descriptor per step-high cycle.
module fuat_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  fuat_pkg::desc_type   desc,
   input  logic [23:0]          max_nal_size,
   output fuat_pkg::result_type res
);

   logic        active_ff;
   logic [7:0]  header_ff;
   logic [15:0] start_seq_ff;
   logic [15:0] expect_seq_ff;
   logic [31:0] timestamp_ff;
   logic [31:0] ssrc_ff;
   logic [6:0]  pay_type_ff;
   logic [23:0] byte_count_ff;

   logic [7:0]  ind;
   logic [7:0]  fuh;
   logic [7:0]  otype;
   logic        is_start;
   logic        is_end;
   logic [15:0] frag;
   logic [23:0] frag_ext;
   logic [24:0] sum;
   logic [7:0]  new_header;
   logic        err_hit;
   fuat_pkg::status_type err_code;
   logic [1:0]  err_off;

   assign ind        = desc.indicator_byte;
   assign fuh        = desc.fu_header_byte;
   assign otype      = fuh & fuat_pkg::TYPE_BITS;
   assign is_start   = (fuh & fuat_pkg::FU_S_BIT) != 8'd0;
   assign is_end     = (fuh & fuat_pkg::FU_E_BIT) != 8'd0;
   assign frag       = desc.payload_len - 16'd2;
   assign frag_ext   = {8'd0, frag};
   assign sum        = {1'b0, byte_count_ff} + {1'b0, frag_ext};
   assign new_header = (ind & fuat_pkg::PREFIX_BITS) | otype;

   always_comb begin
      err_hit  = 1'b1;
      err_code = fuat_pkg::ERR_EMPTY;
      err_off  = 2'd0;
      priority if (desc.payload_len == 16'd0) begin
         err_code = fuat_pkg::ERR_EMPTY;
      end else if (ind[7]) begin
         err_code = fuat_pkg::ERR_FORBIDDEN;
      end else if ((ind & fuat_pkg::TYPE_BITS) != fuat_pkg::FU_A_TYPE) begin
         err_code = fuat_pkg::ERR_IND_TYPE;
      end else if (desc.payload_len == 16'd1) begin
         err_code = fuat_pkg::ERR_TRUNC;
         err_off  = 2'd1;
      end else if ((fuh & fuat_pkg::FU_R_BIT) != 8'd0) begin
         err_code = fuat_pkg::ERR_RESERVED;
         err_off  = 2'd1;
      end else if (is_start && is_end) begin
         err_code = fuat_pkg::ERR_START_END;
         err_off  = 2'd1;
      end else if (otype == 8'd0 || otype > fuat_pkg::MAX_SINGLE) begin
         err_code = fuat_pkg::ERR_ORIG_TYPE;
         err_off  = 2'd1;
      end else if (desc.marker_in && !is_end) begin
         err_code = fuat_pkg::ERR_MARKER;
         err_off  = 2'd1;
      end else if (is_start && active_ff) begin
         err_code = fuat_pkg::ERR_START_ACTIVE;
         err_off  = 2'd1;
      end else if (is_start && frag_ext >= max_nal_size) begin
         // covers a zero limit as well: header byte alone would not fit
         err_code = fuat_pkg::ERR_START_SIZE;
         err_off  = 2'd2;
      end else if (!is_start && !active_ff) begin
         err_code = fuat_pkg::ERR_NO_UNIT;
         err_off  = 2'd1;
      end else if (!is_start && desc.seq_num != expect_seq_ff) begin
         err_code = fuat_pkg::ERR_SEQ;
      end else if (!is_start && desc.stream_ssrc != ssrc_ff) begin
         err_code = fuat_pkg::ERR_SSRC;
      end else if (!is_start && desc.rtp_timestamp != timestamp_ff) begin
         err_code = fuat_pkg::ERR_TIMESTAMP;
      end else if (!is_start && desc.pay_type != pay_type_ff) begin
         err_code = fuat_pkg::ERR_PAY_TYPE;
      end else if (!is_start &&
                   ((ind & fuat_pkg::NRI_BITS) != (header_ff & fuat_pkg::NRI_BITS) ||
                    otype != (header_ff & fuat_pkg::TYPE_BITS))) begin
         err_code = fuat_pkg::ERR_HEADER;
      end else if (!is_start && sum > {1'b0, max_nal_size}) begin
         err_code = fuat_pkg::ERR_TOO_LONG;
         err_off  = 2'd2;
      end else begin
         err_hit = 1'b0;
      end
   end

   always_comb begin
      res = '0;
      if (err_hit) begin
         res.status     = err_code;
         res.err_offset = err_off;
      end else if (is_start) begin
         res.status         = fuat_pkg::ST_ACCEPT;
         res.write_offset   = 24'd1;
         res.unit_header    = new_header;
         res.nal_length     = frag_ext + 24'd1;
         res.first_seq      = desc.seq_num;
         res.unit_timestamp = desc.rtp_timestamp;
         res.unit_ssrc      = desc.stream_ssrc;
         res.unit_active    = 1'b1;
      end else begin
         res.status         = is_end ? fuat_pkg::ST_DONE : fuat_pkg::ST_ACCEPT;
         res.write_offset   = byte_count_ff;
         res.unit_header    = header_ff;
         res.nal_length     = sum[23:0];
         res.first_seq      = start_seq_ff;
         res.last_seq       = is_end ? desc.seq_num : 16'd0;
         res.unit_timestamp = timestamp_ff;
         res.unit_ssrc      = ssrc_ff;
         res.marker_out     = is_end & desc.marker_in;
         res.unit_active    = !is_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (step) begin
         if (err_hit) begin
            active_ff <= 1'b0;
         end else if (is_start) begin
            active_ff <= 1'b1;
         end else if (is_end) begin
            active_ff <= 1'b0;
         end
      end
   end

   // unit payload state; only read while a unit is active
   always_ff @(posedge clock) begin
      if (step && !err_hit) begin
         expect_seq_ff <= desc.seq_num + 16'd1;
         if (is_start) begin
            header_ff     <= new_header;
            start_seq_ff  <= desc.seq_num;
            timestamp_ff  <= desc.rtp_timestamp;
            ssrc_ff       <= desc.stream_ssrc;
            pay_type_ff   <= desc.pay_type;
            byte_count_ff <= frag_ext + 24'd1;
         end else begin
            byte_count_ff <= sum[23:0];
         end
      end
   end

   a_err_closes: assert property (@(posedge clock) disable iff (reset)
      step && err_hit |=> !active_ff)
      else $error("unit still active after a failed packet");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step && res.status == fuat_pkg::ST_DONE |=> !active_ff)
      else $error("unit still active after completion");

   a_progress_match: assert property (@(posedge clock) disable iff (reset)
      step |=> active_ff == $past(res.unit_active))
      else $error("unit_active disagrees with unit state");

   a_start_offset: assert property (@(posedge clock) disable iff (reset)
      step && !active_ff && res.status == fuat_pkg::ST_ACCEPT |-> res.write_offset == 24'd1)
      else $error("start fragment not placed after header byte");

endmodule

### sv/fu_a_fragment_reassembly_tracker.sv
// Top level: stream ports, input and result registers, size-limit register.
//
//  channel | ports                         | beat
//  --------+-------------------------------+------------------------------------
//  req     | req_tvalid/tready/tdata/tlast | one RTP packet descriptor
//  rsp     | rsp_tvalid/tready/tdata/tuser | one status result per packet
//          | rsp_tlast                     |
//  csr     | csr_valid/ready/wdata         | max_nal_size write
//
// Two register stages: a packet beat lands in the input register, is checked
// against the unit state and moves to the result register. Throughput is one
// packet per cycle while rsp_tready is high; rsp_tvalid rises once the beat has
// passed the input register and then the result register. A stalled rsp side holds
// both stages; req_tready drops only in reset or when both are full and rsp_tready
// is low. Reset (synchronous) closes any open unit and sets the limit to 1048576.
module fu_a_fragment_reassembly_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // indicator_byte, fu_header_byte, payload_len, seq_num, rtp_timestamp,
   // stream_ssrc, pay_type, one zero pad bit
   input  logic [fuat_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic        req_tlast,   // marker_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // err_offset, write_offset, unit_header, nal_length, first_seq, last_seq,
   // unit_timestamp, unit_ssrc, unit_active, five zero pad bits
   output logic [fuat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [4:0]  rsp_tuser,   // status
   output logic        rsp_tlast,   // marker_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_wdata    // max_nal_size
);

   logic                 in_valid_ff;
   fuat_pkg::desc_type   in_desc_ff;
   logic                 out_valid_ff;
   fuat_pkg::result_type out_res_ff;
   logic [23:0]          max_size_ff;

   logic                 advance;
   fuat_pkg::result_type res;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign csr_ready  = !reset;

   fuat_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .desc         (in_desc_ff),
      .max_nal_size (max_size_ff),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_size_ff  <= fuat_pkg::MAX_NAL_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            max_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_desc_ff.indicator_byte <= req_tdata[7:0];
         in_desc_ff.fu_header_byte <= req_tdata[15:8];
         in_desc_ff.payload_len    <= req_tdata[31:16];
         in_desc_ff.seq_num        <= req_tdata[47:32];
         in_desc_ff.rtp_timestamp  <= req_tdata[79:48];
         in_desc_ff.stream_ssrc    <= req_tdata[111:80];
         in_desc_ff.pay_type       <= req_tdata[118:112];
         in_desc_ff.marker_in      <= req_tlast;
      end
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.status;
   assign rsp_tlast  = out_res_ff.marker_out;
   assign rsp_tdata  = {5'd0,
                        out_res_ff.unit_active,
                        out_res_ff.unit_ssrc,
                        out_res_ff.unit_timestamp,
                        out_res_ff.last_seq,
                        out_res_ff.first_seq,
                        out_res_ff.nal_length,
                        out_res_ff.unit_header,
                        out_res_ff.write_offset,
                        out_res_ff.err_offset};

endmodule

### tb/sv/tb_fu_a_fragment_reassembly_tracker.sv
// Testbench for the FU-A reassembly tracker: random and directed packets, scoreboard checks.
module tb_fu_a_fragment_reassembly_tracker;

   localparam int CYCLE_LIMIT = 300000;

   // Tracks one NAL unit in flight and holds the results still owed by the block.
   class reassembly_scoreboard;
      fuat_pkg::result_type owed_q[$];
      logic [23:0] size_limit;
      bit          unit_open;
      logic [7:0]  unit_hdr;
      logic [15:0] unit_first_seq;
      logic [15:0] next_seq;
      logic [31:0] unit_ts;
      logic [31:0] unit_ssrc;
      logic [6:0]  unit_pt;
      logic [23:0] unit_bytes;
      int          err_count;

      function new();
         size_limit     = fuat_pkg::MAX_NAL_RESET;
         unit_open      = 1'b0;
         unit_hdr       = '0;
         unit_first_seq = '0;
         next_seq       = '0;
         unit_ts        = '0;
         unit_ssrc      = '0;
         unit_pt        = '0;
         unit_bytes     = '0;
         err_count      = 0;
      endfunction

      function void set_limit(logic [23:0] v);
         size_limit = v;
      endfunction

      function fuat_pkg::result_type abort_unit(fuat_pkg::status_type code, logic [1:0] at);
         fuat_pkg::result_type r;
         unit_open    = 1'b0;
         r            = '0;
         r.status     = code;
         r.err_offset = at;
         return r;
      endfunction

      function void note_packet(fuat_pkg::desc_type d);
         fuat_pkg::result_type r;
         logic [23:0] frag;
         logic [4:0]  otype;
         bit          s_bit;
         bit          e_bit;
         s_bit = d.fu_header_byte[7];
         e_bit = d.fu_header_byte[6];
         otype = d.fu_header_byte[4:0];
         frag  = 24'(d.payload_len) - 24'd2;
         r     = '0;
         if (d.payload_len == 16'd0)
            r = abort_unit(fuat_pkg::ERR_EMPTY, 2'd0);
         else if (d.indicator_byte[7])
            r = abort_unit(fuat_pkg::ERR_FORBIDDEN, 2'd0);
         else if ((d.indicator_byte & fuat_pkg::TYPE_BITS) != fuat_pkg::FU_A_TYPE)
            r = abort_unit(fuat_pkg::ERR_IND_TYPE, 2'd0);
         else if (d.payload_len < 16'd2)
            r = abort_unit(fuat_pkg::ERR_TRUNC, d.payload_len[1:0]);
         else if ((d.fu_header_byte & fuat_pkg::FU_R_BIT) != 0)
            r = abort_unit(fuat_pkg::ERR_RESERVED, 2'd1);
         else if (s_bit && e_bit)
            r = abort_unit(fuat_pkg::ERR_START_END, 2'd1);
         else if (otype == 5'd0 || 8'(otype) > fuat_pkg::MAX_SINGLE)
            r = abort_unit(fuat_pkg::ERR_ORIG_TYPE, 2'd1);
         else if (d.marker_in && !e_bit)
            r = abort_unit(fuat_pkg::ERR_MARKER, 2'd1);
         else if (s_bit && unit_open)
            r = abort_unit(fuat_pkg::ERR_START_ACTIVE, 2'd1);
         else if (s_bit && (size_limit == 24'd0 || frag > size_limit - 24'd1))
            r = abort_unit(fuat_pkg::ERR_START_SIZE, 2'd2);
         else if (s_bit) begin
            unit_open      = 1'b1;
            unit_hdr       = (d.indicator_byte & fuat_pkg::PREFIX_BITS) | 8'(otype);
            unit_first_seq = d.seq_num;
            next_seq       = d.seq_num + 16'd1;
            unit_ts        = d.rtp_timestamp;
            unit_ssrc      = d.stream_ssrc;
            unit_pt        = d.pay_type;
            unit_bytes     = frag + 24'd1;
            r.status         = fuat_pkg::ST_ACCEPT;
            r.write_offset   = 24'd1;
            r.unit_header    = unit_hdr;
            r.nal_length     = unit_bytes;
            r.first_seq      = unit_first_seq;
            r.unit_timestamp = unit_ts;
            r.unit_ssrc      = unit_ssrc;
            r.unit_active    = 1'b1;
         end
         else if (!unit_open)
            r = abort_unit(fuat_pkg::ERR_NO_UNIT, 2'd1);
         else if (d.seq_num != next_seq)
            r = abort_unit(fuat_pkg::ERR_SEQ, 2'd0);
         else if (d.stream_ssrc != unit_ssrc)
            r = abort_unit(fuat_pkg::ERR_SSRC, 2'd0);
         else if (d.rtp_timestamp != unit_ts)
            r = abort_unit(fuat_pkg::ERR_TIMESTAMP, 2'd0);
         else if (d.pay_type != unit_pt)
            r = abort_unit(fuat_pkg::ERR_PAY_TYPE, 2'd0);
         else if (((d.indicator_byte ^ unit_hdr) & fuat_pkg::NRI_BITS) != 0 ||
                  otype != unit_hdr[4:0])
            r = abort_unit(fuat_pkg::ERR_HEADER, 2'd0);
         else if (32'(unit_bytes) + 32'(frag) > 32'(size_limit))
            r = abort_unit(fuat_pkg::ERR_TOO_LONG, 2'd2);
         else begin
            r.write_offset   = unit_bytes;
            unit_bytes       = unit_bytes + frag;
            next_seq         = d.seq_num + 16'd1;
            r.unit_header    = unit_hdr;
            r.nal_length     = unit_bytes;
            r.first_seq      = unit_first_seq;
            r.unit_timestamp = unit_ts;
            r.unit_ssrc      = unit_ssrc;
            if (e_bit) begin
               unit_open     = 1'b0;
               r.status      = fuat_pkg::ST_DONE;
               r.last_seq    = d.seq_num;
               r.marker_out  = d.marker_in;
               r.unit_active = 1'b0;
            end else begin
               r.status      = fuat_pkg::ST_ACCEPT;
               r.unit_active = 1'b1;
            end
         end
         // newest at the front, oldest taken from the back
         owed_q.push_front(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
         end
      endfunction

      function void check_result(fuat_pkg::result_type got);
         fuat_pkg::result_type want;
         if (owed_q.size() == 0) begin
            $error("result beat with nothing owed, status %0d", got.status);
            err_count++;
            return;
         end
         want = owed_q.pop_back();
         compare_field("status", want.status, got.status);
         compare_field("err_offset", want.err_offset, got.err_offset);
         compare_field("write_offset", want.write_offset, got.write_offset);
         compare_field("unit_header", want.unit_header, got.unit_header);
         compare_field("nal_length", want.nal_length, got.nal_length);
         compare_field("first_seq", want.first_seq, got.first_seq);
         compare_field("last_seq", want.last_seq, got.last_seq);
         compare_field("unit_timestamp", want.unit_timestamp, got.unit_timestamp);
         compare_field("unit_ssrc", want.unit_ssrc, got.unit_ssrc);
         compare_field("marker_out", want.marker_out, got.marker_out);
         compare_field("unit_active", want.unit_active, got.unit_active);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [fuat_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [fuat_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [4:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [23:0]           csr_wdata = '0;

   reassembly_scoreboard sb = new();
   int                   cycles = 0;
   int                   pkts_sent = 0;
   bit                   req_idle_on = 1'b1;
   bit                   rsp_idle_on = 1'b1;

   fu_a_fragment_reassembly_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_fu_a_fragment_reassembly_tracker: errors");
         $finish;
      end
   end

   // Idle stretches switch on and off now and then so back-to-back runs also occur.
   function automatic int idle_draw(ref bit mode);
      if ($urandom_range(0, 39) == 0)
         mode = !mode;
      return mode ? int'($urandom_range(0, 15)) : 0;
   endfunction

   task automatic send_pkt(fuat_pkg::desc_type d);
      int gap;
      gap = idle_draw(req_idle_on);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, d.pay_type, d.stream_ssrc, d.rtp_timestamp, d.seq_num,
                     d.payload_len, d.fu_header_byte, d.indicator_byte};
      req_tlast  <= d.marker_in;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_packet(d);
      pkts_sent++;
   endtask

   task automatic send(logic [7:0] ind, logic [7:0] fuh, logic [15:0] plen, logic [15:0] seq,
                       logic [31:0] ts, logic [31:0] ssrc, logic [6:0] pt, logic mark);
      fuat_pkg::desc_type d;
      d = '{ind, fuh, plen, seq, ts, ssrc, pt, mark};
      send_pkt(d);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      // pipeline is two stages deep
      repeat (6) @(posedge clock);
   endtask

   task automatic write_limit(logic [23:0] v);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_limit(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] frag_len();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom_range(0, 65535));
         1:       return 16'd65535;
         2:       return 16'd2;
         default: return 16'($urandom_range(3, 300));
      endcase
   endfunction

   function automatic void corrupt(inout fuat_pkg::desc_type d);
      case ($urandom_range(0, 12))
         0:  d.payload_len = 16'($urandom_range(0, 1));
         1:  d.indicator_byte[7] = 1'b1;
         2:  d.indicator_byte[4:0] = 5'($urandom_range(0, 31));
         3:  d.fu_header_byte = d.fu_header_byte | fuat_pkg::FU_R_BIT;
         4:  d.fu_header_byte = d.fu_header_byte | fuat_pkg::FU_S_BIT | fuat_pkg::FU_E_BIT;
         5:  d.fu_header_byte[4:0] = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(24, 31));
         6:  d.marker_in = 1'b1;
         7:  d.seq_num = d.seq_num + 16'($urandom_range(1, 65535));
         8:  d.stream_ssrc = d.stream_ssrc ^ (32'd1 << $urandom_range(0, 31));
         9:  d.rtp_timestamp = d.rtp_timestamp ^ (32'd1 << $urandom_range(0, 31));
         10: d.pay_type = d.pay_type ^ (7'd1 << $urandom_range(0, 6));
         11: begin
            if ($urandom_range(0, 1))
               d.indicator_byte = d.indicator_byte ^ (8'h20 << $urandom_range(0, 1));
            else
               d.fu_header_byte[4:0] = 5'($urandom_range(1, 23));
         end
         default: d.fu_header_byte[7] = ~d.fu_header_byte[7];
      endcase
   endfunction

   // Start, up to four middles, end; now and then a fragment is spoiled or the unit cut short.
   task automatic rand_unit();
      fuat_pkg::desc_type d;
      logic [15:0] seq0;
      logic [7:0]  ind;
      logic [4:0]  otype;
      int          middles;
      seq0    = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                            : 16'($urandom);
      ind     = {1'b0, 2'($urandom_range(0, 3)), 5'd28};
      otype   = 5'($urandom_range(1, 23));
      middles = $urandom_range(0, 4);
      d.rtp_timestamp = $urandom;
      d.stream_ssrc   = $urandom;
      d.pay_type      = 7'($urandom_range(0, 127));
      for (int i = 0; i <= middles + 1; i++) begin
         d.indicator_byte = ind;
         d.fu_header_byte = {i == 0, i == middles + 1, 1'b0, otype};
         d.payload_len    = frag_len();
         d.seq_num        = seq0 + 16'(i);
         d.marker_in      = (i == middles + 1) ? 1'($urandom_range(0, 1)) : 1'b0;
         if ($urandom_range(0, 9) == 0)
            corrupt(d);
         send_pkt(d);
         if (i > 0 && $urandom_range(0, 19) == 0)
            break;
      end
   endtask

   task automatic noise_pkt();
      fuat_pkg::desc_type d;
      d.indicator_byte = $urandom_range(0, 1) ? {1'b0, 2'($urandom_range(0, 3)), 5'd28}
                                              : 8'($urandom);
      d.fu_header_byte = 8'($urandom);
      d.payload_len    = frag_len();
      d.seq_num        = 16'($urandom);
      d.rtp_timestamp  = $urandom;
      d.stream_ssrc    = $urandom;
      d.pay_type       = 7'($urandom);
      d.marker_in      = 1'($urandom);
      send_pkt(d);
   endtask

   // Result side: random stalls, every beat checked against the oldest owed result.
   initial begin
      fuat_pkg::result_type got;
      int         gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = idle_draw(rsp_idle_on);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.status         = fuat_pkg::status_type'(rsp_tuser);
         got.err_offset     = rsp_tdata[1:0];
         got.write_offset   = rsp_tdata[25:2];
         got.unit_header    = rsp_tdata[33:26];
         got.nal_length     = rsp_tdata[57:34];
         got.first_seq      = rsp_tdata[73:58];
         got.last_seq       = rsp_tdata[89:74];
         got.unit_timestamp = rsp_tdata[121:90];
         got.unit_ssrc      = rsp_tdata[153:122];
         got.unit_active    = rsp_tdata[154];
         got.marker_out     = rsp_tlast;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      logic [7:0]  ind;
      logic [31:0] ts;
      logic [31:0] ss;
      logic [23:0] phase_limit [7];
      logic [23:0] lim;
      int          phase_start;
      phase_limit = '{24'hFFFFFF, 24'd2000, 24'd0, 24'd1, 24'd700, 24'd0,
                      fuat_pkg::MAX_NAL_RESET};
      ind = 8'h7C;
      ts  = 32'hDEAD_BEEF;
      ss  = 32'h1234_5678;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // malformed descriptors, in check order
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd0, 16'd1, ts, ss, 7'd96, 1'b0);
      send(8'hFC, fuat_pkg::FU_S_BIT | 8'd5, 16'd10, 16'd1, ts, ss, 7'd96, 1'b0);
      send(8'h7B, fuat_pkg::FU_S_BIT | 8'd5, 16'd10, 16'd1, ts, ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd1, 16'd1, ts, ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | fuat_pkg::FU_R_BIT | 8'd5, 16'd10, 16'd1, ts, ss,
           7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | fuat_pkg::FU_E_BIT | 8'd5, 16'd10, 16'd1, ts, ss,
           7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT, 16'd10, 16'd1, ts, ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd31, 16'd10, 16'd1, ts, ss, 7'd96, 1'b0);
      send(ind, 8'd5, 16'd10, 16'd1, ts, ss, 7'd96, 1'b1);
      send(ind, 8'd5, 16'd10, 16'd1, ts, ss, 7'd96, 1'b0);
      // largest start, then a second start while it is open
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd65535, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           7'd127, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd10, 16'd3, ts, ss, 7'd96, 1'b0);
      // sequence wraps through zero, then a gap; ssrc, timestamp, pay_type, header mismatches
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd100, 16'hFFFF, ts, ss, 7'd96, 1'b0);
      send(ind, 8'd5, 16'd2, 16'd0, ts, ss, 7'd96, 1'b0);
      send(ind, 8'd5, 16'd20, 16'd5, ts, ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd20, 16'd10, ts, ss, 7'd96, 1'b0);
      send(ind, 8'd5, 16'd20, 16'd11, ts, ~ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd20, 16'd20, ts, ss, 7'd96, 1'b0);
      send(ind, 8'd5, 16'd20, 16'd21, ts ^ 32'd1, ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd20, 16'd30, ts, ss, 7'd96, 1'b0);
      send(ind, 8'd5, 16'd20, 16'd31, ts, ss, 7'd0, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd20, 16'd40, ts, ss, 7'd96, 1'b0);
      send(8'h5C, 8'd5, 16'd20, 16'd41, ts, ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd20, 16'd50, ts, ss, 7'd96, 1'b0);
      send(ind, 8'd6, 16'd20, 16'd51, ts, ss, 7'd96, 1'b0);
      // limit lowered below the open unit's size
      send(8'h1C, fuat_pkg::FU_S_BIT | 8'd1, 16'd1002, 16'd60, ts, ss, 7'd96, 1'b0);
      write_limit(24'd500);
      send(8'h1C, 8'd1, 16'd2, 16'd61, ts, ss, 7'd96, 1'b0);
      // zero limit refuses every start; limit one admits a header-only unit
      write_limit(24'd0);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd2, 16'd70, ts, ss, 7'd96, 1'b0);
      write_limit(24'd1);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd2, 16'd80, ts, ss, 7'd96, 1'b0);
      send(ind, fuat_pkg::FU_E_BIT | 8'd5, 16'd2, 16'd81, ts, ss, 7'd96, 1'b1);
      send(ind, fuat_pkg::FU_S_BIT | 8'd5, 16'd3, 16'd82, ts, ss, 7'd96, 1'b0);

      for (int p = 0; p < 7; p++) begin
         lim = (p == 5) ? 24'($urandom) : phase_limit[p];
         write_limit(lim);
         phase_start = pkts_sent;
         while (pkts_sent - phase_start < 70) begin
            if ($urandom_range(0, 99) < 82)
               rand_unit();
            else
               noise_pkt();
         end
      end

      drain();
      if (sb.err_count == 0)
         $display("tb_fu_a_fragment_reassembly_tracker: clean");
      else
         $display("tb_fu_a_fragment_reassembly_tracker: errors");
      $finish;
   end

endmodule

### files.f
sv/fuat_pkg.sv
sv/fuat_core.sv
sv/fu_a_fragment_reassembly_tracker.sv
tb/sv/tb_fu_a_fragment_reassembly_tracker.sv
